// File: rtl/core/lba_pkg.sv
// ----------------------------------------------------------------------------
// lba_pkg
// Shared types and constants for the linked block append allocator: request
// and result items, register indexes, status and action codes.
// ----------------------------------------------------------------------------
package lba_pkg;

    localparam int NUM_BLOCKS_DEF      = 1024;
    localparam int MAX_BLOCK_BYTES_DEF = 4096;
    localparam int MIN_BLOCK_BYTES     = 128;
    localparam int MAX_DATA_LEN        = 4096;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'd1;

    localparam logic ACT_CLAIM  = 1'b0;
    localparam logic ACT_APPEND = 1'b1;

    localparam logic ST_OK           = 1'b0;
    localparam logic ST_OUT_OF_BLOCK = 1'b1;

    typedef struct packed {
        logic        action;
        logic [9:0]  first_block;
        logic [12:0] data_length;
    } req_t;

    typedef struct packed {
        logic [9:0]  block_index;
        logic [11:0] byte_offset;
        logic [12:0] byte_count;
        logic        last;
        logic        status;
    } rsp_t;

endpackage

// File: rtl/core/linked_block_append_allocator.sv
// ----------------------------------------------------------------------------
// linked_block_append_allocator
// Block table allocator: claims free blocks and appends byte runs to linked
// block chains, giving one placement item per piece or an out-of-blocks result.
// ----------------------------------------------------------------------------
// The whole block table (used mark, link, fill count) lives in one RAM with a
// registered read, so the block handles one request item at a time. After reset
// a clearing pass writes every table entry before the first item is taken;
// configuration writes are taken during it. A claim item costs a first-fit
// scan of the table up to the first free block. An append item first walks the
// chain, reading and then following each link, then places the tail piece and
// runs one scan for every new block it links in. Results leave through an output
// register, so a stalled consumer only holds the engine when the next result is
// due.
// ----------------------------------------------------------------------------
module linked_block_append_allocator #(
    parameter int NUM_BLOCKS      = lba_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_BLOCK_BYTES = lba_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lba_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  lba_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output lba_pkg::rsp_t                  rsp
);

    import lba_pkg::*;

    localparam int IW     = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
    localparam int RW     = (IW > 10) ? IW : 10;
    localparam int FW     = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int BW     = (FW > 13) ? FW : 13;
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int LIM_W  = (CNT_W > 11) ? CNT_W : 11;
    localparam int ENT_W  = 2 + IW + FW;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RED    = 4'd2;
    localparam logic [3:0] S_WRD    = 4'd3;
    localparam logic [3:0] S_WCK    = 4'd4;
    localparam logic [3:0] S_PLACE  = 4'd5;
    localparam logic [3:0] S_CSTART = 4'd6;
    localparam logic [3:0] S_SCAN   = 4'd7;
    localparam logic [3:0] S_LINK   = 4'd8;
    localparam logic [3:0] S_WNEW   = 4'd9;
    localparam logic [3:0] S_FAIL   = 4'd10;

    typedef struct packed {
        logic          used;
        logic          lvalid;
        logic [IW-1:0] link;
        logic [FW-1:0] fill;
    } ent_t;

    // configuration
    logic [12:0] block_bytes_reg;
    logic [10:0] blocks_in_use_reg;

    // control state
    logic [3:0]       state_reg, state_next;
    logic [IW-1:0]    clr_reg, clr_next;
    logic [RW-1:0]    red_reg, red_next;
    logic [IW-1:0]    cur_reg, cur_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic [CNT_W-1:0] used_count_reg, used_count_next;
    logic [LIM_W-1:0] scan_reg, scan_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IW-1:0]    pend_addr_reg, pend_addr_next;
    logic [IW-1:0]    nb_reg, nb_next;
    logic             dirty_reg, dirty_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // payload state
    ent_t          cur_ent_reg, cur_ent_next;
    logic [BW-1:0] len_reg, len_next;
    rsp_t          rsp_reg, rsp_next;

    // table RAM ports
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    ent_t          mem_wdata;
    logic [IW-1:0] mem_raddr;
    ent_t          mem_rdata;

    logic [BW-1:0]    bb;
    logic [LIM_W-1:0] limit;
    logic             slot_free;
    logic             emit_en;
    rsp_t             emit_data;
    logic [BW-1:0]    fill_w;
    logic [BW-1:0]    freesp;
    logic [BW-1:0]    piece;
    logic [BW-1:0]    len_rest;

    lba_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    function automatic rsp_t mk_rsp(
        input logic [IW-1:0] blk,
        input logic [BW-1:0] off,
        input logic [BW-1:0] cnt,
        input logic          lst,
        input logic          st
    );
        rsp_t          r;
        logic [RW-1:0] blk_w;
        blk_w         = RW'(blk);
        r.block_index = blk_w[9:0];
        r.byte_offset = off[11:0];
        r.byte_count  = cnt[12:0];
        r.last        = lst;
        r.status      = st;
        return r;
    endfunction

    // Clamp block size to the legal range and the allocation limit to the table.
    always_comb
    begin
        if (BW'(block_bytes_reg) < BW'(MIN_BLOCK_BYTES))
        begin
            bb = BW'(MIN_BLOCK_BYTES);
        end
        else if (BW'(block_bytes_reg) > BW'(MAX_BLOCK_BYTES))
        begin
            bb = BW'(MAX_BLOCK_BYTES);
        end
        else
        begin
            bb = BW'(block_bytes_reg);
        end

        if (LIM_W'(blocks_in_use_reg) > LIM_W'(NUM_BLOCKS))
        begin
            limit = LIM_W'(NUM_BLOCKS);
        end
        else
        begin
            limit = LIM_W'(blocks_in_use_reg);
        end
    end

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign fill_w    = BW'(cur_ent_reg.fill);
    assign freesp    = (fill_w < bb) ? (bb - fill_w) : '0;
    assign piece     = (len_reg <= bb) ? len_reg : bb;
    assign len_rest  = len_reg - piece;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        red_next        = red_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        used_count_next = used_count_reg;
        scan_next       = scan_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        nb_next         = nb_reg;
        dirty_next      = dirty_reg;
        cur_ent_next    = cur_ent_reg;
        len_next        = len_reg;

        mem_we    = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = cur_ent_reg;
        mem_raddr = cur_reg;
        emit_en   = 1'b0;
        emit_data = mk_rsp(cur_reg, fill_w, '0, 1'b1, ST_OK);
        req_ready = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Write reset contents: block 0 is marked used.
                mem_we         = 1'b1;
                mem_waddr      = clr_reg;
                mem_wdata      = '0;
                mem_wdata.used = (clr_reg == '0);
                clr_next       = clr_reg + 1'b1;
                if (clr_reg == IW'(NUM_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                req_ready  = 1'b1;
                dirty_next = 1'b0;
                if (req_valid)
                begin
                    if (req.action == ACT_CLAIM)
                    begin
                        len_next   = '0;
                        state_next = S_CSTART;
                    end
                    else
                    begin
                        red_next   = RW'(req.first_block);
                        len_next   = (req.data_length > 13'(MAX_DATA_LEN))
                                     ? BW'(MAX_DATA_LEN) : BW'(req.data_length);
                        steps_next = '0;
                        state_next = S_RED;
                    end
                end
            end

            S_RED:
            begin
                // Reduce the chain start into the table, one subtract a cycle.
                if ((RW + 1)'(red_reg) >= (RW + 1)'(NUM_BLOCKS))
                begin
                    red_next = red_reg - RW'(NUM_BLOCKS);
                end
                else
                begin
                    cur_next   = red_reg[IW-1:0];
                    state_next = S_WRD;
                end
            end

            S_WRD:
            begin
                mem_raddr  = cur_reg;
                state_next = S_WCK;
            end

            S_WCK:
            begin
                // Follow the link, or stop at the tail or once NUM_BLOCKS links have been followed.
                if (mem_rdata.lvalid && (steps_reg < CNT_W'(NUM_BLOCKS)))
                begin
                    cur_next   = mem_rdata.link;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WRD;
                end
                else
                begin
                    cur_ent_next = mem_rdata;
                    state_next   = S_PLACE;
                end
            end

            S_PLACE:
            begin
                if (freesp >= len_reg)
                begin
                    if (slot_free)
                    begin
                        emit_en        = 1'b1;
                        emit_data      = mk_rsp(cur_reg, fill_w, len_reg, 1'b1, ST_OK);
                        mem_we         = 1'b1;
                        mem_waddr      = cur_reg;
                        mem_wdata      = cur_ent_reg;
                        mem_wdata.fill = FW'(fill_w + len_reg);
                        state_next     = S_IDLE;
                    end
                end
                else if (freesp != '0)
                begin
                    if (slot_free)
                    begin
                        emit_en           = 1'b1;
                        emit_data         = mk_rsp(cur_reg, fill_w, freesp, 1'b0, ST_OK);
                        cur_ent_next.fill = FW'(bb);
                        dirty_next        = 1'b1;
                        len_next          = len_reg - freesp;
                        state_next        = S_CSTART;
                    end
                end
                else
                begin
                    state_next = S_CSTART;
                end
            end

            S_CSTART:
            begin
                scan_next       = '0;
                pend_valid_next = 1'b0;
                if (LIM_W'(used_count_reg) >= limit)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle and check the one returned.
                mem_raddr = scan_reg[IW-1:0];
                if (pend_valid_reg && !mem_rdata.used)
                begin
                    nb_next    = pend_addr_reg;
                    state_next = (dirty_reg || (len_reg != '0)) ? S_LINK : S_WNEW;
                end
                else if (scan_reg < limit)
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = scan_reg[IW-1:0];
                    scan_next       = scan_reg + 1'b1;
                end
                else if (pend_valid_reg)
                begin
                    pend_valid_next = 1'b0;
                end
                else
                begin
                    state_next = S_FAIL;
                end
            end

            S_LINK:
            begin
                // Link the current tail to the new block and write it back.
                mem_we           = 1'b1;
                mem_waddr        = cur_reg;
                mem_wdata        = cur_ent_reg;
                mem_wdata.lvalid = 1'b1;
                mem_wdata.link   = nb_reg;
                dirty_next       = 1'b0;
                state_next       = S_WNEW;
            end

            S_WNEW:
            begin
                if (slot_free)
                begin
                    emit_en         = 1'b1;
                    emit_data       = mk_rsp(nb_reg, '0, piece, (len_rest == '0), ST_OK);
                    mem_we          = 1'b1;
                    mem_waddr       = nb_reg;
                    mem_wdata       = '0;
                    mem_wdata.used  = 1'b1;
                    mem_wdata.fill  = FW'(piece);
                    if ((len_reg != '0) && (nb_reg == cur_reg))
                    begin
                        // A free tail that claims itself keeps the link to itself.
                        mem_wdata.lvalid = 1'b1;
                        mem_wdata.link   = nb_reg;
                    end
                    used_count_next = used_count_reg + 1'b1;
                    len_next        = len_rest;
                    cur_next        = nb_reg;
                    cur_ent_next    = mem_wdata;
                    state_next      = (len_rest == '0) ? S_IDLE : S_CSTART;
                end
            end

            S_FAIL:
            begin
                if (slot_free)
                begin
                    emit_en    = 1'b1;
                    emit_data  = mk_rsp('0, '0, '0, 1'b1, ST_OUT_OF_BLOCK);
                    mem_we     = dirty_reg;
                    mem_waddr  = cur_reg;
                    mem_wdata  = cur_ent_reg;
                    dirty_next = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (emit_en)
        begin
            rsp_next       = emit_data;
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg   <= 13'd1024;
            blocks_in_use_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLOCK_BYTES:   block_bytes_reg   <= cfg_wdata;
                REG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_wdata[10:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            red_reg        <= '0;
            cur_reg        <= '0;
            steps_reg      <= '0;
            used_count_reg <= CNT_W'(1);
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_addr_reg  <= '0;
            nb_reg         <= '0;
            dirty_reg      <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            red_reg        <= red_next;
            cur_reg        <= cur_next;
            steps_reg      <= steps_next;
            used_count_reg <= used_count_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= pend_valid_next;
            pend_addr_reg  <= pend_addr_next;
            nb_reg         <= nb_next;
            dirty_reg      <= dirty_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_ent_reg <= cur_ent_next;
        len_reg     <= len_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Never count more claimed blocks than the table holds.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= CNT_W'(NUM_BLOCKS))
        else $error("used count above table size");

    // The table is never written while waiting for an item.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("table write while idle");

    // Every claimed block bumps the used count by one.
    a_claim_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WNEW && slot_free) |=>
            (used_count_reg == $past(used_count_reg) + 1'b1))
        else $error("used count not advanced on claim");

    // An out-of-blocks result carries no placement.
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_OUT_OF_BLOCK) |->
            (rsp.block_index == '0 && rsp.byte_count == '0 && rsp.last))
        else $error("out-of-blocks result with placement");

endmodule

// File: rtl/core/lba_ram.sv
// ----------------------------------------------------------------------------
// lba_ram
// Generic simple dual port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module lba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
